// File: src/rntr_pkg.sv
// rntr_pkg: shared types, constants and helpers for the RSSI neighbor table router.
// No dependencies.
`timescale 1ns / 1ps
package rntr_pkg;

    localparam int TABLE_ENTRIES_DEF = 4;
    localparam int CNT_W             = 5;

    typedef enum logic [1:0] {
        KIND_BEACON = 2'd0,
        KIND_DECAY  = 2'd1,
        KIND_DATA   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        CFG_ROOT_ADDR = 3'd0,
        CFG_IS_ROOT   = 3'd1,
        CFG_HYST      = 3'd2,
        CFG_MAX_HOPS  = 3'd3,
        CFG_DECAY     = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEARN,
        ST_SORT,
        ST_DIV,
        ST_DECAY,
        ST_COMPACT,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [15:0]       addr;
        logic signed [7:0] rssi;
        logic [15:0]       oldest_seq;
        logic [15:0]       newest_seq;
        logic [15:0]       uniq;
        logic [15:0]       cnt;
        logic [15:0]       ratio;
    } row_t;

    // per-cell command from the controller
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_UPDATE,
        CMD_WRITE_NEW,
        CMD_DECAY,
        CMD_SET_RATIO,
        CMD_LOAD
    } cmd_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [15:0]       addr;
        logic signed [7:0] rssi;
        logic [15:0]       seq;
        logic [15:0]       decay;
        logic [15:0]       ratio;
    } cell_ctl_t;

    function automatic logic seq_ahead(input logic [15:0] s, input logic [15:0] r);
        logic [15:0] d;
        begin
            d = s - r;
            seq_ahead = (s != r) && !d[15];
        end
    endfunction

endpackage

// File: src/rntr_cell.sv
// rntr_cell: one neighbor table entry with its local update logic.
// Depends on rntr_pkg.
`timescale 1ns / 1ps
module rntr_cell
    import rntr_pkg::*;
(
    input  logic      aclk,
    input  logic      sel,
    input  cell_ctl_t ctl,
    input  row_t      load_row,
    output row_t      row
);

    row_t row_reg, row_next;
    logic signed [9:0] sm;
    logic [15:0] c;

    always_comb begin
        row_next = row_reg;
        sm = 10'(3 * 10'(row_reg.rssi)) + 10'(ctl.rssi);
        sm = (sm < 0) ? -((-sm) >>> 2) : (sm >>> 2);
        c  = (row_reg.cnt > ctl.decay) ? row_reg.cnt - ctl.decay : 16'd0;
        case (ctl.cmd)
            CMD_UPDATE: if (sel) begin
                row_next.rssi = sm[7:0];
                if (seq_ahead(ctl.seq, row_reg.newest_seq)) begin
                    row_next.uniq       = row_reg.uniq + 16'd1;
                    row_next.newest_seq = ctl.seq;
                end
                if (row_reg.cnt != 16'hFFFF) row_next.cnt = row_reg.cnt + 16'd1;
            end
            CMD_WRITE_NEW: if (sel) begin
                row_next.addr       = ctl.addr;
                row_next.rssi       = ctl.rssi;
                row_next.oldest_seq = ctl.seq;
                row_next.newest_seq = ctl.seq;
                row_next.uniq       = 16'd1;
                row_next.cnt        = 16'd1;
                row_next.ratio      = 16'd1000;
            end
            CMD_DECAY:     row_next.cnt = c;
            CMD_SET_RATIO: if (sel) row_next.ratio = ctl.ratio;
            CMD_LOAD:      if (sel) row_next = load_row;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        row_reg <= row_next;
    end

    assign row = row_reg;

endmodule

// File: src/rntr_div.sv
// rntr_div: bit-serial unsigned divider, 32 by 16, one quotient bit per cycle.
// Depends on rntr_pkg.
`timescale 1ns / 1ps
module rntr_div
    import rntr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic [15:0] d_reg, d_next;
    logic [5:0]  n_reg, n_next;
    logic        busy_reg, busy_next;
    logic [16:0] t;

    always_comb begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg;
        n_next = n_reg; busy_next = busy_reg;
        t = {r_reg[15:0], q_reg[31]};
        if (start) begin
            q_next = dividend; r_next = '0; d_next = divisor;
            n_next = 6'd32; busy_next = 1'b1;
        end else if (busy_reg) begin
            if (t >= {1'b0, d_reg}) begin
                r_next = t - {1'b0, d_reg};
                q_next = {q_reg[30:0], 1'b1};
            end else begin
                r_next = t;
                q_next = {q_reg[30:0], 1'b0};
            end
            n_next = n_reg - 6'd1;
            if (n_reg == 6'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            n_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            n_reg    <= n_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done     = busy_reg && (n_reg == 6'd1);
    assign quotient = q_next;

endmodule

// File: src/rssi_neighbor_table_router.sv
// rssi_neighbor_table_router: top level, controller over a row of table cells.
// Depends on rntr_pkg, rntr_cell, rntr_div.
//
// channel | dir | handshake           | payload
// s_      | in  | s_valid / s_ready   | kind, addresses, rssi, sequence, hop, ttl
// m_      | out | m_valid / m_ready   | decisions, entry status, table count
// cfg_    | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One word at a time. Steps per word: root beacon: update, exchange sort (one
// compare/swap step per cycle), serial ratio division; rejected newcomer: no table
// write, sort; decay: counter decay, compaction, sort; data: forward or deliver decision;
// foreign beacon or undefined kind: straight to the result word.
// Reset clears control state; table rows are valid below the entry count only.
// s_ready drops from acceptance until the result word is taken; m_ready low adds cycles.
`timescale 1ns / 1ps
module rssi_neighbor_table_router
    import rntr_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_kind,
    input  logic [15:0]       s_peer_address,
    input  logic signed [7:0] s_rssi_sample,
    input  logic [15:0]       s_beacon_sequence,
    input  logic [7:0]        s_beacon_hop,
    input  logic [15:0]       s_origin_address,
    input  logic [7:0]        s_data_ttl,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_rebroadcast,
    output logic [7:0]        m_rebroadcast_hop,
    output logic              m_forward,
    output logic [15:0]       m_next_hop_address,
    output logic [7:0]        m_forward_ttl,
    output logic              m_delivered,
    output logic              m_entry_accepted,
    output logic signed [7:0] m_entry_rssi,
    output logic [15:0]       m_entry_delivery_ratio,
    output logic [CNT_W-1:0]  m_table_count
);

    localparam int N  = TABLE_ENTRIES;
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int CW = $clog2(N + 1);

    // configuration
    logic [15:0] root_addr_reg, decay_step_reg;
    logic        is_root_reg;
    logic [7:0]  hyst_reg, max_hops_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_addr_reg  <= 16'd256;
            is_root_reg    <= 1'b0;
            hyst_reg       <= 8'd3;
            max_hops_reg   <= 8'd6;
            decay_step_reg <= 16'd1;
        end else if (cfg_valid) begin
            case (cfg_idx_t'(cfg_index))
                CFG_ROOT_ADDR: root_addr_reg  <= cfg_data;
                CFG_IS_ROOT:   is_root_reg    <= cfg_data[0];
                CFG_HYST:      hyst_reg       <= cfg_data[7:0];
                CFG_MAX_HOPS:  max_hops_reg   <= cfg_data[7:0];
                CFG_DECAY:     decay_step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // cell row
    row_t        rows [N];
    logic [N-1:0] sel;
    row_t        load_row [N];
    cell_ctl_t   ctl;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            rntr_cell u_cell (
                .aclk    (aclk),
                .sel     (sel[g]),
                .ctl     (ctl),
                .load_row(load_row[g]),
                .row     (rows[g])
            );
        end
    endgenerate

    // divider
    logic        div_start, div_done;
    logic [31:0] div_dividend, div_q;
    logic [15:0] div_divisor;

    rntr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dividend(div_dividend),
        .divisor (div_divisor),
        .done    (div_done),
        .quotient(div_q)
    );

    // controller state
    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0]   lastf_reg, lastf_next;
    logic [CW-1:0] a_reg, a_next, b_reg, b_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] ai, bi;
    logic [1:0]        kind_reg;
    logic [15:0]       peer_reg, seq_reg;
    logic signed [7:0] rssi_reg;
    logic [7:0]        hop_reg, ttl_reg;

    logic              o_rb_reg, o_fw_reg, o_dl_reg, o_acc_reg;
    logic [7:0]        o_rbh_reg, o_ttl_reg;
    logic [15:0]       o_nh_reg, o_ratio_reg;
    logic signed [7:0] o_rssi_reg;
    logic              o_rb_next, o_fw_next, o_dl_next, o_acc_next;
    logic [7:0]        o_rbh_next, o_ttl_next;
    logic [15:0]       o_nh_next, o_ratio_next;
    logic signed [7:0] o_rssi_next;

    // lookup over the row (independent compares)
    logic [N-1:0]  hit;
    logic          any_hit;
    logic [IW-1:0] hit_idx, weak_idx;
    logic [15:0]   est;
    logic signed [9:0] thr;

    assign ai = a_reg[IW-1:0];
    assign bi = b_reg[IW-1:0];

    always_comb begin
        any_hit = 1'b0;
        hit_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            hit[i] = (CW'(i) < cnt_reg) && (rows[i].addr == peer_reg);
            if (hit[i]) begin
                any_hit = 1'b1;
                hit_idx = IW'(i);
            end
        end
    end

    // weakest entry: first index of minimum, sequential-style scan of N cells
    always_comb begin
        weak_idx = '0;
        for (int i = 1; i < N; i++)
            if (rows[i].rssi < rows[weak_idx].rssi) weak_idx = IW'(i);
    end

    assign thr = 10'(rows[weak_idx].rssi) + 10'(signed'({2'b0, hyst_reg}));
    assign est = rows[k_reg].newest_seq - rows[k_reg].oldest_seq + 16'd1;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        lastf_next = lastf_reg;
        a_next = a_reg; b_next = b_reg; k_next = k_reg;
        sel = '0;
        ctl = '{cmd: CMD_HOLD, addr: peer_reg, rssi: rssi_reg, seq: seq_reg,
                decay: decay_step_reg, ratio: 16'd0};
        for (int i = 0; i < N; i++) load_row[i] = rows[i];
        div_start    = 1'b0;
        div_dividend = 32'(rows[k_reg].uniq) * 32'd1000;
        div_divisor  = est;
        o_rb_next = o_rb_reg; o_rbh_next = o_rbh_reg; o_fw_next = o_fw_reg;
        o_nh_next = o_nh_reg; o_ttl_next = o_ttl_reg; o_dl_next = o_dl_reg;
        o_acc_next = o_acc_reg; o_rssi_next = o_rssi_reg; o_ratio_next = o_ratio_reg;
        s_ready = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    o_rb_next = 1'b0; o_rbh_next = '0; o_fw_next = 1'b0;
                    o_nh_next = '0; o_ttl_next = '0; o_dl_next = 1'b0;
                    o_acc_next = 1'b0; o_rssi_next = '0; o_ratio_next = '0;
                    a_next = '0; b_next = CW'(1); k_next = '0;
                    case (kind_t'(s_kind))
                        KIND_BEACON: state_next = (s_origin_address == root_addr_reg)
                                                  ? ST_LEARN : ST_OUT;
                        KIND_DECAY:  state_next = ST_DECAY;
                        KIND_DATA:   state_next = ST_FINISH;
                        default:     state_next = ST_OUT;
                    endcase
                end
            end
            ST_LEARN: begin
                if (any_hit) begin
                    sel[hit_idx] = 1'b1;
                    ctl.cmd = CMD_UPDATE;
                end else if (cnt_reg < CW'(N)) begin
                    sel[cnt_reg[IW-1:0]] = 1'b1;
                    ctl.cmd  = CMD_WRITE_NEW;
                    cnt_next = cnt_reg + CW'(1);
                end else if (!(10'(rssi_reg) < thr)) begin
                    sel[weak_idx] = 1'b1;
                    ctl.cmd = CMD_WRITE_NEW;
                end
                state_next = ST_SORT;
                a_next = '0; b_next = CW'(1);
            end
            ST_SORT: begin
                if (N > 1 && b_reg < cnt_reg) begin
                    if (rows[bi].rssi > rows[ai].rssi) begin
                        sel[ai] = 1'b1; sel[bi] = 1'b1;
                        ctl.cmd = CMD_LOAD;
                        load_row[ai] = rows[bi];
                        load_row[bi] = rows[ai];
                    end
                    if (b_reg + CW'(1) < cnt_reg) begin
                        b_next = b_reg + CW'(1);
                    end else begin
                        a_next = a_reg + CW'(1);
                        b_next = a_reg + CW'(2);
                    end
                end else begin
                    state_next = (kind_reg == KIND_BEACON) ? ST_DIV : ST_OUT;
                    k_next = hit_idx;
                    a_next = '0;
                end
            end
            ST_DIV: begin
                // k_reg points at the sender's entry after sorting
                if (!any_hit) begin
                    state_next = ST_FINISH;
                end else if (k_reg != hit_idx) begin
                    k_next = hit_idx;
                end else if (a_reg == '0) begin
                    if (est == 16'd0) begin
                        sel[k_reg] = 1'b1;
                        ctl.cmd = CMD_SET_RATIO;
                        ctl.ratio = 16'd0;
                        state_next = ST_FINISH;
                    end else begin
                        div_start = 1'b1;
                        a_next = CW'(1);
                    end
                end else if (div_done) begin
                    sel[k_reg] = 1'b1;
                    ctl.cmd = CMD_SET_RATIO;
                    ctl.ratio = (div_q[31:16] != 16'd0) ? 16'hFFFF : div_q[15:0];
                    state_next = ST_FINISH;
                end
            end
            ST_DECAY: begin
                if (CW'(k_reg) < cnt_reg && N > 0) begin
                    ctl.cmd = CMD_DECAY;
                    state_next = ST_COMPACT;
                end else begin
                    state_next = ST_SORT;
                    a_next = '0; b_next = CW'(1);
                end
            end
            ST_COMPACT: begin
                // walk entries: drop zero counters by moving the last row in
                if (CW'(k_reg) < cnt_reg) begin
                    if (rows[k_reg].cnt == 16'd0) begin
                        if (CW'(k_reg) + CW'(1) < cnt_reg) begin
                            sel[k_reg] = 1'b1;
                            ctl.cmd = CMD_LOAD;
                            load_row[k_reg] = rows[IW'(cnt_reg - CW'(1))];
                        end
                        cnt_next = cnt_reg - CW'(1);
                    end else begin
                        k_next = k_reg + IW'(1);
                        if (CW'(k_reg) + CW'(1) >= cnt_reg) begin
                            state_next = ST_SORT;
                            a_next = '0; b_next = CW'(1);
                        end
                    end
                end else begin
                    state_next = ST_SORT;
                    a_next = '0; b_next = CW'(1);
                end
            end
            ST_FINISH: begin
                if (kind_reg == KIND_BEACON) begin
                    o_acc_next = any_hit;
                    o_rssi_next = any_hit ? rows[hit_idx].rssi : 8'sd0;
                    o_ratio_next = any_hit ? rows[hit_idx].ratio : 16'd0;
                    if (!is_root_reg && seq_ahead(seq_reg, lastf_reg)
                        && hop_reg < max_hops_reg) begin
                        lastf_next = seq_reg;
                        o_rb_next  = 1'b1;
                        o_rbh_next = hop_reg + 8'd1;
                    end
                end else if (is_root_reg) begin
                    o_dl_next = 1'b1;
                end else if (ttl_reg != 8'd0 && cnt_reg != '0
                             && rows[0].addr != peer_reg) begin
                    o_fw_next  = 1'b1;
                    o_nh_next  = rows[0].addr;
                    o_ttl_next = ttl_reg - 8'd1;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            lastf_reg <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            lastf_reg <= lastf_next;
        end
        a_reg <= a_next; b_reg <= b_next; k_reg <= k_next;
        if (s_valid && s_ready) begin
            kind_reg <= s_kind; peer_reg <= s_peer_address;
            rssi_reg <= s_rssi_sample; seq_reg <= s_beacon_sequence;
            hop_reg <= s_beacon_hop;
            ttl_reg <= s_data_ttl;
        end
        o_rb_reg <= o_rb_next; o_rbh_reg <= o_rbh_next; o_fw_reg <= o_fw_next;
        o_nh_reg <= o_nh_next; o_ttl_reg <= o_ttl_next; o_dl_reg <= o_dl_next;
        o_acc_reg <= o_acc_next; o_rssi_reg <= o_rssi_next;
        o_ratio_reg <= o_ratio_next;
    end

    assign m_valid                = (state_reg == ST_OUT);
    assign m_rebroadcast          = o_rb_reg;
    assign m_rebroadcast_hop      = o_rbh_reg;
    assign m_forward              = o_fw_reg;
    assign m_next_hop_address     = o_nh_reg;
    assign m_forward_ttl          = o_ttl_reg;
    assign m_delivered            = o_dl_reg;
    assign m_entry_accepted       = o_acc_reg;
    assign m_entry_rssi           = o_rssi_reg;
    assign m_entry_delivery_ratio = o_ratio_reg;
    assign m_table_count          = CNT_W'(cnt_reg);

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(N)) else $error("entry count above table size");
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input taken while result pending");
    a_fwd_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_forward && m_delivered)) else $error("forward and deliver");
    a_cnt_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT) && !m_ready |=> $stable(cnt_reg))
        else $error("table changed while result waits");

endmodule
